FILE: sv/least_squares_line_fit_top_macros.svh
// Assertion macros shared by the least-squares line fit RTL.
`ifndef LEAST_SQUARES_LINE_FIT_TOP_MACROS_SVH
`define LEAST_SQUARES_LINE_FIT_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Property checked on every rising clock edge outside reset.
`define LSLF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition that must never be true outside reset.
`define LSLF_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define LSLF_ASSERT(lbl, prop, msg)
`define LSLF_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

FILE: sv/lslf_pkg.sv
// Shared widths, codes and interface types of the least-squares line fit.
package lslf_pkg;

  // Sample fields and accumulators.
  localparam int unsigned TIME_W   = 16;
  localparam int unsigned VAL_W    = 16;
  localparam int unsigned CNT_W    = 13;
  localparam int unsigned TSUM_W   = 28;
  localparam int unsigned SQ_W     = 44;
  localparam int unsigned PP_W     = 32;
  localparam int unsigned MAX_SAMPLES_DEF = 4096;

  // Fit arithmetic.
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned Q_W      = 32;
  localparam int unsigned MUL_A_W  = 44;
  localparam int unsigned MUL_B_W  = 28;
  localparam int unsigned PROD_W   = 60;
  localparam int unsigned MAG_W    = 56;
  localparam int unsigned DVS_W    = 56;
  localparam int unsigned REM_W    = 57;
  localparam int unsigned STR_W    = 52;
  localparam int unsigned QUO_W    = 52;
  localparam int unsigned STEP_W   = 6;

  // Stream payload widths.
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned IN_TDATA_W  = ((TIME_W + VAL_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((2 * Q_W + CNT_W + 7) / 8) * 8;

  localparam logic [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_DEGEN = 2'd1,
    ST_DROP  = 2'd2
  } fit_status_e;

  typedef struct packed {
    logic start;
    logic clear;
  } acc_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

FILE: sv/least_squares_line_fit_top.sv
// Top level of the least-squares straight-line fit over Q8.8 sample sets.
// Samples arrive on the s_axis channel, one transfer each: tdata holds the time in
// bits 15:0 and the value in bits 31:16, and tlast marks the final sample of a set.
// Each sample passes through the bit-serial product unit inside the accumulator,
// and tready is low while that unit is busy.
// The transfer with tlast starts the fit, which runs on one shared serial
// multiplier and one serial divider; a set with fewer than two samples skips
// both units. No sample is taken while the fit runs.
// Each result is one m_axis transfer: intercept and slope in Q16.16, samples used,
// and a status in tuser. It sits in an output register, so the next set can be
// collected while the receiver stalls; a finished fit waits until that slot drains.
// Samples beyond MAX_SAMPLES are dropped and reported in the status.
// Reset clears all sums, the sequencer and the output valid flag.
`include "least_squares_line_fit_top_macros.svh"

module least_squares_line_fit_top import lslf_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // sample_time[15:0], sample_value[31:16]
  input  logic                   s_axis_tlast,   // last_sample
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // intercept[31:0], slope[63:32],
                                                 // samples_used[76:64], zero fill
  output logic [STATUS_W-1:0]    m_axis_tuser    // fit_status[1:0]
);

  localparam logic [CNT_W-1:0]  MaxCnt   = CNT_W'(MAX_SAMPLES);
  localparam logic [CNT_W-1:0]  MinFitN  = CNT_W'(2);
  localparam logic [QUO_W-1:0]  NegLimit = QUO_W'(1) << (Q_W - 1);
  localparam logic [QUO_W-1:0]  PosLimit = NegLimit - 1'b1;

  // One-hot sequencer: collect samples, form numerator and denominator, divide.
  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_WAIT = 11'b000_0000_0010,
    S_M1   = 11'b000_0000_0100,
    S_M2   = 11'b000_0000_1000,
    S_M3   = 11'b000_0001_0000,
    S_M4   = 11'b000_0010_0000,
    S_CHK  = 11'b000_0100_0000,
    S_DIV1 = 11'b000_1000_0000,
    S_M5   = 11'b001_0000_0000,
    S_DIV2 = 11'b010_0000_0000,
    S_DONE = 11'b100_0000_0000
  } state_e;

  // Applies the sign to a quotient magnitude and clamps it to Q16.16.
  function automatic logic [Q_W-1:0] sat_q32(input logic neg, input logic [QUO_W-1:0] mag);
    logic [Q_W-1:0] res;
    if (neg) begin
      res = (mag > NegLimit) ? Q_MIN : ('0 - mag[Q_W-1:0]);
    end else begin
      res = (mag > PosLimit) ? Q_MAX : mag[Q_W-1:0];
    end
    return res;
  endfunction

  state_e state_q, state_d;
  logic   launch_q, overflow_q, out_valid_q;

  logic in_xfer, room, res_load, out_free;

  // Accumulator.
  acc_ctrl_t                acc_ctrl;
  logic                     acc_busy;
  logic [CNT_W-1:0]         acc_count;
  logic signed [TSUM_W-1:0] acc_tsum, acc_vsum;
  logic signed [SQ_W-1:0]   acc_ttsum, acc_txsum;

  // Shared arithmetic units.
  logic                      mul_start, div_start;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  unit_stat_t                mul_stat, div_stat;
  logic [REM_W-1:0]          div_rem;
  logic [STR_W-1:0]          div_str;
  logic [STEP_W-1:0]         div_steps;
  logic [DVS_W-1:0]          div_dvs;
  logic [QUO_W-1:0]          div_quo;

  // Fit intermediates and result.
  logic signed [PROD_W-1:0] num_q, den_q, inum_q, sx_scaled;
  logic [PROD_W-1:0]        num_abs, inum_abs;
  logic [MAG_W-1:0]         num_mag;
  logic                     num_neg, den_le0, slope_sat, few_samples;
  logic signed [MUL_B_W-1:0] n_ext;
  logic [Q_W-1:0]           res_slope_q, res_icpt_q;
  fit_status_e              res_status_q;

  // Output register.
  logic [Q_W-1:0]   out_slope_q, out_icpt_q;
  logic [CNT_W-1:0] out_n_q;
  fit_status_e      out_status_q;

  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && !acc_busy;
  assign room          = (acc_count < MaxCnt);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign res_load      = (state_q == S_DONE) && out_free;

  assign acc_ctrl.start = in_xfer && room;
  assign acc_ctrl.clear = res_load;

  lslf_accum u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (acc_ctrl),
    .time_i  (signed'(s_axis_tdata[TIME_W-1:0])),
    .value_i (signed'(s_axis_tdata[TIME_W+VAL_W-1:TIME_W])),
    .busy_o  (acc_busy),
    .count_o (acc_count),
    .tsum_o  (acc_tsum),
    .vsum_o  (acc_vsum),
    .ttsum_o (acc_ttsum),
    .txsum_o (acc_txsum)
  );

  // Derived values of the fit.
  assign few_samples = (acc_count < MinFitN);
  assign n_ext       = signed'({{(MUL_B_W-CNT_W){1'b0}}, acc_count});
  assign num_neg     = num_q[PROD_W-1];
  assign num_abs     = num_neg ? (~num_q + 1'b1) : num_q;
  assign num_mag     = num_abs[MAG_W-1:0];
  assign den_le0     = den_q[PROD_W-1] || (den_q == '0);
  // The slope quotient reaches 2^32 exactly when |num| >= den * 2^16.
  assign slope_sat   = {{FRAC_W{1'b0}}, num_mag} >= {den_q[MAG_W-1:0], {FRAC_W{1'b0}}};
  assign sx_scaled   = {{(PROD_W-TSUM_W-FRAC_W){acc_vsum[TSUM_W-1]}}, acc_vsum,
                        {FRAC_W{1'b0}}};
  assign inum_abs    = inum_q[PROD_W-1] ? (~inum_q + 1'b1) : inum_q;

  // A unit starts in the first cycle of each state that uses it.
  assign mul_start = launch_q && (state_q inside {S_M1, S_M2, S_M3, S_M4, S_M5});
  assign div_start = launch_q && (state_q inside {S_DIV1, S_DIV2});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_M1: begin
        mul_a = acc_txsum;
        mul_b = n_ext;
      end
      S_M2: begin
        mul_a = MUL_A_W'(acc_vsum);
        mul_b = acc_tsum;
      end
      S_M3: begin
        mul_a = acc_ttsum;
        mul_b = n_ext;
      end
      S_M4: begin
        mul_a = MUL_A_W'(acc_tsum);
        mul_b = acc_tsum;
      end
      S_M5: begin
        mul_a = MUL_A_W'(signed'(res_slope_q));
        mul_b = acc_tsum;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Slope: (|num| * 2^16) / den. Intercept: (|Sx*2^16 - slope*St| / 2^8) / n.
  always_comb begin
    if (state_q == S_DIV1) begin
      div_rem   = {{(REM_W-MAG_W+FRAC_W){1'b0}}, num_mag[MAG_W-1:FRAC_W]};
      div_str   = {num_mag[FRAC_W-1:0], {(STR_W-FRAC_W){1'b0}}};
      div_steps = STEP_W'(2 * FRAC_W);
      div_dvs   = den_q[DVS_W-1:0];
    end else begin
      div_rem   = '0;
      div_str   = inum_abs[PROD_W-1:PROD_W-STR_W];
      div_steps = STEP_W'(STR_W);
      div_dvs   = {{(DVS_W-CNT_W){1'b0}}, acc_count};
    end
  end

  lslf_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .stat_o  (mul_stat),
    .prod_o  (mul_p)
  );

  lslf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .rem_init_i (div_rem),
    .stream_i   (div_str),
    .steps_i    (div_steps),
    .divisor_i  (div_dvs),
    .stat_o     (div_stat),
    .quo_o      (div_quo)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer && s_axis_tlast) state_d = S_WAIT;
      end
      S_WAIT: begin
        if (!acc_busy) state_d = few_samples ? S_DONE : S_M1;
      end
      S_M1: begin
        if (mul_stat.done) state_d = S_M2;
      end
      S_M2: begin
        if (mul_stat.done) state_d = S_M3;
      end
      S_M3: begin
        if (mul_stat.done) state_d = S_M4;
      end
      S_M4: begin
        if (mul_stat.done) state_d = S_CHK;
      end
      S_CHK: begin
        if (den_le0) begin
          state_d = S_DONE;
        end else if (slope_sat) begin
          state_d = S_M5;
        end else begin
          state_d = S_DIV1;
        end
      end
      S_DIV1: begin
        if (div_stat.done) state_d = S_M5;
      end
      S_M5: begin
        if (mul_stat.done) state_d = S_DIV2;
      end
      S_DIV2: begin
        if (div_stat.done) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      launch_q    <= 1'b0;
      overflow_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      launch_q <= (state_d != state_q);
      if (res_load) begin
        overflow_q <= 1'b0;
      end else if (in_xfer && !room) begin
        overflow_q <= 1'b1;
      end
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_WAIT: begin
        if (!acc_busy && few_samples) begin
          res_status_q <= ST_DEGEN;
          res_slope_q  <= '0;
          res_icpt_q   <= '0;
        end
      end
      S_M1: begin
        if (mul_stat.done) num_q <= mul_p;
      end
      S_M2: begin
        if (mul_stat.done) num_q <= num_q - mul_p;
      end
      S_M3: begin
        if (mul_stat.done) den_q <= mul_p;
      end
      S_M4: begin
        if (mul_stat.done) den_q <= den_q - mul_p;
      end
      S_CHK: begin
        if (den_le0) begin
          res_status_q <= ST_DEGEN;
          res_slope_q  <= '0;
          res_icpt_q   <= '0;
        end else begin
          res_status_q <= overflow_q ? ST_DROP : ST_OK;
          if (slope_sat) res_slope_q <= num_neg ? Q_MIN : Q_MAX;
        end
      end
      S_DIV1: begin
        if (div_stat.done) res_slope_q <= sat_q32(num_neg, div_quo);
      end
      S_M5: begin
        if (mul_stat.done) inum_q <= sx_scaled - mul_p;
      end
      S_DIV2: begin
        if (div_stat.done) res_icpt_q <= sat_q32(inum_q[PROD_W-1], div_quo);
      end
      default: begin
      end
    endcase

    if (res_load) begin
      out_slope_q  <= res_slope_q;
      out_icpt_q   <= res_icpt_q;
      out_status_q <= res_status_q;
      out_n_q      <= acc_count;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-2*Q_W-CNT_W){1'b0}}, out_n_q, out_slope_q, out_icpt_q};
  assign m_axis_tuser  = out_status_q;

  // The sequencer never runs the multiplier and the divider together.
  `LSLF_ASSERT_NEVER(a_units_exclusive, mul_stat.busy && div_stat.busy, "mul and div overlap")
  // Dropped samples never reach the sums.
  `LSLF_ASSERT(a_count_bound, acc_count <= MaxCnt, "sample count beyond capacity")
  // Handing a result to the output register empties the set.
  `LSLF_ASSERT(a_clear_after_fit, res_load |=> (acc_count == '0) && !overflow_q,
               "set not cleared after fit")
  // A degenerate result carries zero slope and intercept.
  `LSLF_ASSERT(a_degen_zero,
               (m_axis_tvalid && (m_axis_tuser == ST_DEGEN)) |-> (m_axis_tdata[2*Q_W-1:0] == '0),
               "degenerate fit with nonzero fields")

endmodule

FILE: sv/lslf_accum.sv
// Sample accumulator with a bit-serial unit for the squared and cross products.
module lslf_accum import lslf_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  acc_ctrl_t                ctrl_i,
  input  logic signed [TIME_W-1:0] time_i,
  input  logic signed [VAL_W-1:0]  value_i,
  output logic                     busy_o,
  output logic [CNT_W-1:0]         count_o,
  output logic signed [TSUM_W-1:0] tsum_o,
  output logic signed [TSUM_W-1:0] vsum_o,
  output logic signed [SQ_W-1:0]   ttsum_o,
  output logic signed [SQ_W-1:0]   txsum_o
);

  logic [CNT_W-1:0]         count_q;
  logic signed [TSUM_W-1:0] tsum_q, vsum_q;
  logic signed [SQ_W-1:0]   ttsum_q, txsum_q;
  logic [TIME_W-1:0]        mplr_q;
  logic signed [PP_W-1:0]   mct_q, mcx_q;
  logic                     t_neg;
  logic [TIME_W-1:0]        t_mag;
  logic signed [PP_W-1:0]   x_ext;

  // The multiplier is the magnitude of the time; the sign moves onto the value multiplicand only.
  assign t_neg  = time_i[TIME_W-1];
  assign t_mag  = t_neg ? TIME_W'(-time_i) : TIME_W'(time_i);
  assign x_ext  = PP_W'(value_i);
  assign busy_o = (mplr_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      tsum_q  <= '0;
      vsum_q  <= '0;
      ttsum_q <= '0;
      txsum_q <= '0;
      mplr_q  <= '0;
    end else if (ctrl_i.clear) begin
      count_q <= '0;
      tsum_q  <= '0;
      vsum_q  <= '0;
      ttsum_q <= '0;
      txsum_q <= '0;
      mplr_q  <= '0;
    end else if (ctrl_i.start) begin
      count_q <= count_q + 1'b1;
      tsum_q  <= tsum_q + TSUM_W'(time_i);
      vsum_q  <= vsum_q + TSUM_W'(value_i);
      mplr_q  <= t_mag;
    end else if (busy_o) begin
      mplr_q <= mplr_q >> 1;
      if (mplr_q[0]) begin
        ttsum_q <= ttsum_q + SQ_W'(mct_q);
        txsum_q <= txsum_q + SQ_W'(mcx_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      mct_q <= signed'({{(PP_W-TIME_W){1'b0}}, t_mag});
      mcx_q <= t_neg ? -x_ext : x_ext;
    end else if (busy_o) begin
      mct_q <= mct_q <<< 1;
      mcx_q <= mcx_q <<< 1;
    end
  end

  assign count_o = count_q;
  assign tsum_o  = tsum_q;
  assign vsum_o  = vsum_q;
  assign ttsum_o = ttsum_q;
  assign txsum_o = txsum_q;

endmodule

FILE: sv/lslf_mul.sv
// Bit-serial signed shift-and-add multiplier, one multiplier bit per cycle.
module lslf_mul import lslf_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [MUL_A_W-1:0] a_i,
  input  logic signed [MUL_B_W-1:0] b_i,
  output unit_stat_t                stat_o,
  output logic signed [PROD_W-1:0]  prod_o
);

  localparam int unsigned MCNT_W = $clog2(MUL_B_W);

  logic                     busy_q, done_q;
  logic [MCNT_W-1:0]        cnt_q;
  logic signed [PROD_W-1:0] mcand_q, acc_q, a_ext;
  logic [MUL_B_W-1:0]       mplr_q, b_mag;
  logic                     b_neg;

  assign a_ext = PROD_W'(a_i);
  assign b_neg = b_i[MUL_B_W-1];
  assign b_mag = b_neg ? MUL_B_W'(-b_i) : MUL_B_W'(b_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= MCNT_W'(MUL_B_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Partial sums wrap modulo 2^PROD_W; the final product is exact only when it fits in PROD_W bits.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q <= b_neg ? -a_ext : a_ext;
      mplr_q  <= b_mag;
      acc_q   <= '0;
    end else if (busy_q) begin
      mcand_q <= mcand_q <<< 1;
      mplr_q  <= mplr_q >> 1;
      if (mplr_q[0]) begin
        acc_q <= acc_q + mcand_q;
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign prod_o      = acc_q;

endmodule

FILE: sv/lslf_div.sv
// Restoring unsigned divider that retires one quotient bit per cycle.
module lslf_div import lslf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [REM_W-1:0]   rem_init_i,
  input  logic [STR_W-1:0]   stream_i,
  input  logic [STEP_W-1:0]  steps_i,
  input  logic [DVS_W-1:0]   divisor_i,
  output unit_stat_t         stat_o,
  output logic [QUO_W-1:0]   quo_o
);

  logic               busy_q, done_q;
  logic [STEP_W-1:0]  cnt_q;
  logic [REM_W-1:0]   rem_q, r_sh;
  logic [STR_W-1:0]   str_q;
  logic [QUO_W-1:0]   quo_q;
  logic [DVS_W-1:0]   dvs_q;
  logic [REM_W:0]     diff;
  logic               fits;

  // The remainder stays below the divisor, so its top bit is always clear.
  assign r_sh = {rem_q[REM_W-2:0], str_q[STR_W-1]};
  assign diff = {1'b0, r_sh} - {{(REM_W+1-DVS_W){1'b0}}, dvs_q};
  assign fits = !diff[REM_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i - 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_init_i;
      str_q <= stream_i;
      quo_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[REM_W-1:0] : r_sh;
      str_q <= str_q << 1;
      quo_q <= {quo_q[QUO_W-2:0], fits};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = quo_q;

endmodule
